>>> hw/rtl/bdq_pkg.sv
// Shared types for the bounded deque with search: operation codes and payload types.
package bdq_pkg;

    // Operation codes carried by a command item.
    typedef enum logic [2:0] {
        OP_ADD_FRONT = 3'd0,
        OP_ADD_BACK  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_BACK  = 3'd3,
        OP_COUNT     = 3'd4,
        OP_FIND      = 3'd5,
        OP_LENGTH    = 3'd6,
        OP_CLEAR     = 3'd7
    } t_op;

    // Stored value and the fixed-width result fields.
    typedef logic signed [31:0] t_data;
    typedef logic [4:0]         t_occ;
    typedef logic [4:0]         t_tally;
    typedef logic [3:0]         t_pos;

endpackage

>>> hw/rtl/bdq_if.sv
// Valid/ready channel interfaces for command items and response items.
interface bdq_cmd_if;
    logic           valid;
    logic           ready;
    bdq_pkg::t_op   op;
    bdq_pkg::t_data value;
    bdq_pkg::t_occ  occurrence;

    modport source (output valid, output op, output value, output occurrence, input ready);
    modport sink   (input valid, input op, input value, input occurrence, output ready);
endinterface

interface bdq_rsp_if;
    logic             valid;
    logic             ready;
    bdq_pkg::t_data   removed_value;
    bdq_pkg::t_tally  tally;
    bdq_pkg::t_pos    position;
    logic             found;
    logic             still_nonempty;
    logic             rejected;

    modport source (output valid, output removed_value, output tally, output position,
                    output found, output still_nonempty, output rejected, input ready);
    modport sink   (input valid, input removed_value, input tally, input position,
                    input found, input still_nonempty, input rejected, output ready);
endinterface

>>> hw/rtl/bdq_store.sv
// Entry storage: one write port and one read port with registered read data.
module bdq_store #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  bdq_pkg::t_data             i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output bdq_pkg::t_data             o_rd_data
);

    bdq_pkg::t_data r_mem [DEPTH];
    bdq_pkg::t_data r_rd_data;

    // Write and registered read share one clocked block.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/bounded_deque_with_search_top.sv
// Top level of the bounded deque with search: sequencer, pointers and match unit.
//
// The block keeps up to DEPTH signed 32-bit values in a circular buffer and serves one
// command item at a time. An accepted command goes from the idle state to the execute
// state and then to the output state; a removal from a non-empty store also passes
// through a read-wait state, since its value comes through the registered read port of
// the entry memory. Count and find walk the stored entries through that single read port
// and one equality comparator, one entry per cycle, and stay in the scan state for a
// closing check after the last compare before the response is offered (find stops early
// once the requested occurrence is seen). While the response waits, no new command is
// taken. The entry memory needs no clearing after reset, so the block is ready as soon
// as reset is released.
module bounded_deque_with_search_top #(
    parameter int DEPTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bdq_cmd_if.sink   i_cmd,
    bdq_rsp_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCAN,
        S_OUT
    } t_state;

    t_state          r_state,    n_state;
    bdq_pkg::t_op    r_op,       n_op;
    bdq_pkg::t_data  r_value,    n_value;
    bdq_pkg::t_occ   r_occ,      n_occ;
    logic [AW-1:0]   r_head,     n_head;
    logic [CW-1:0]   r_count,    n_count;
    logic [CW-1:0]   r_k,        n_k;
    logic            r_pend,     n_pend;
    logic [AW-1:0]   r_pk,       n_pk;
    logic [CW-1:0]   r_match,    n_match;
    bdq_pkg::t_data  r_removed,  n_removed;
    logic [CW-1:0]   r_tally,    n_tally;
    logic [AW-1:0]   r_pos,      n_pos;
    logic            r_found,    n_found;
    logic            r_nonempty, n_nonempty;
    logic            r_rejected, n_rejected;

    logic            c_wr_en;
    logic [AW-1:0]   c_wr_addr;
    logic            c_rd_en;
    logic [AW-1:0]   c_k;
    logic [AW:0]     c_sum;
    logic [AW-1:0]   c_slot;
    logic            c_issue;
    logic            c_hit;
    logic [CW-1:0]   c_match_inc;
    bdq_pkg::t_data  c_rd_data;

    // Offset selection feeding the shared slot adder.
    always_comb begin
        c_k = r_k[AW-1:0];
        if (r_state == S_EXEC) begin
            unique case (r_op)
                bdq_pkg::OP_ADD_BACK: c_k = AW'(r_count);
                bdq_pkg::OP_REM_BACK: c_k = AW'(r_count - CW'(1));
                default:              c_k = '0;
            endcase
        end
    end

    // Shared slot adder: (head + offset) wrapped at DEPTH with one compare and subtract.
    assign c_sum  = {1'b0, r_head} + {1'b0, c_k};
    assign c_slot = (c_sum >= DEPTH_W) ? AW'(c_sum - DEPTH_W) : c_sum[AW-1:0];

    // Scan issue and the shared equality comparator.
    assign c_issue     = (r_state == S_SCAN) && (r_k < r_count) && !r_found;
    assign c_hit       = r_pend && (c_rd_data == r_value);
    assign c_match_inc = r_match + CW'(1);

    // Next-state and datapath sequencing.
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_value    = r_value;
        n_occ      = r_occ;
        n_head     = r_head;
        n_count    = r_count;
        n_k        = r_k;
        n_pend     = 1'b0;
        n_pk       = r_pk;
        n_match    = r_match;
        n_removed  = r_removed;
        n_tally    = r_tally;
        n_pos      = r_pos;
        n_found    = r_found;
        n_nonempty = r_nonempty;
        n_rejected = r_rejected;
        c_wr_en    = 1'b0;
        c_wr_addr  = c_slot;
        c_rd_en    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op       = i_cmd.op;
                    n_value    = i_cmd.value;
                    n_occ      = i_cmd.occurrence;
                    n_removed  = '0;
                    n_tally    = '0;
                    n_pos      = '0;
                    n_found    = 1'b0;
                    n_nonempty = 1'b0;
                    n_rejected = 1'b0;
                    n_k        = '0;
                    n_match    = '0;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                unique case (r_op)
                    bdq_pkg::OP_ADD_FRONT: begin
                        if (r_count == FULL_C) begin
                            n_rejected = 1'b1;
                        end else begin
                            n_head    = (r_head == '0) ? LAST_A : r_head - AW'(1);
                            c_wr_en   = 1'b1;
                            c_wr_addr = n_head;
                            n_count   = r_count + CW'(1);
                        end
                    end
                    bdq_pkg::OP_ADD_BACK: begin
                        if (r_count == FULL_C) begin
                            n_rejected = 1'b1;
                        end else begin
                            c_wr_en = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    bdq_pkg::OP_REM_FRONT, bdq_pkg::OP_REM_BACK: begin
                        if (r_count != '0) begin
                            c_rd_en = 1'b1;
                            n_state = S_RDWAIT;
                        end
                    end
                    bdq_pkg::OP_COUNT, bdq_pkg::OP_FIND: begin
                        n_state = S_SCAN;
                    end
                    bdq_pkg::OP_LENGTH: begin
                        n_tally = r_count;
                    end
                    bdq_pkg::OP_CLEAR: begin
                        n_count = '0;
                        n_head  = '0;
                    end
                endcase
            end
            S_RDWAIT: begin
                // The removed value arrives from the read port this cycle.
                n_removed  = c_rd_data;
                n_count    = r_count - CW'(1);
                n_nonempty = (r_count != CW'(1));
                if (r_op == bdq_pkg::OP_REM_FRONT) begin
                    n_head = (r_head == LAST_A) ? '0 : r_head + AW'(1);
                end
                n_state = S_OUT;
            end
            S_SCAN: begin
                // Issue one read per cycle and compare the entry read the cycle before.
                if (c_issue) begin
                    c_rd_en = 1'b1;
                    n_pend  = 1'b1;
                    n_pk    = r_k[AW-1:0];
                    n_k     = r_k + CW'(1);
                end
                if (c_hit && !r_found) begin
                    if (r_op == bdq_pkg::OP_COUNT) begin
                        n_tally = r_tally + CW'(1);
                    end else begin
                        n_match = c_match_inc;
                        if ((r_occ != '0) && (32'(c_match_inc) == 32'(r_occ))) begin
                            n_found = 1'b1;
                            n_pos   = r_pk;
                        end
                    end
                end
                if (!c_issue && !r_pend) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // State, pointers and registered response fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_op       <= n_op;
        r_value    <= n_value;
        r_occ      <= n_occ;
        r_k        <= n_k;
        r_pk       <= n_pk;
        r_match    <= n_match;
        r_removed  <= n_removed;
        r_tally    <= n_tally;
        r_pos      <= n_pos;
        r_found    <= n_found;
        r_nonempty <= n_nonempty;
        r_rejected <= n_rejected;
    end

    // Entry memory.
    bdq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (c_wr_en),
        .i_wr_addr (c_wr_addr),
        .i_wr_data (r_value),
        .i_rd_en   (c_rd_en),
        .i_rd_addr (c_slot),
        .o_rd_data (c_rd_data)
    );

    // Channel handshakes and response payload.
    assign i_cmd.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = (r_state == S_OUT);
    assign o_rsp.removed_value  = r_removed;
    assign o_rsp.tally          = 5'(r_tally);
    assign o_rsp.position       = 4'(r_pos);
    assign o_rsp.found          = r_found;
    assign o_rsp.still_nonempty = r_nonempty;
    assign o_rsp.rejected       = r_rejected;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_C)
        else $error("entry count exceeds capacity");

    // The front pointer always names a slot inside the buffer.
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < DEPTH_W)
        else $error("head pointer out of range");

    // A pending compare always refers to a stored entry.
    a_pend_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ((r_state == S_SCAN) && ({1'b0, r_pk} < (AW + 1)'(r_count))))
        else $error("scan compare outside stored entries");

    // Only an add can be rejected.
    a_reject_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.rejected) |->
            ((r_op == bdq_pkg::OP_ADD_FRONT) || (r_op == bdq_pkg::OP_ADD_BACK)))
        else $error("rejection flagged on a non-add operation");

    // An accepted command item closes the command channel on the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command accepted while another is in progress");

endmodule
